[design/sred_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_pkg
// Shared types, constants and the symbol lookup for the radix digit emitter.
// ----------------------------------------------------------------------------
package sred_pkg;

	// symbol alphabet geometry
	localparam int SYM_W     = 8;
	localparam int NUM_SYMS  = 16;
	localparam int SYM_IDX_W = 4;
	localparam int BASE_W    = 5;
	localparam int REG_W     = 64;
	localparam int ADDR_W    = 5;

	// reserved characters
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'd45;
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'd43;
	localparam logic [SYM_W-1:0] SYM_NUL   = 8'd0;

	// configuration as seen by the sequencer
	typedef struct packed {
		logic [BASE_W-1:0]          base_size;
		logic [NUM_SYMS*SYM_W-1:0]  alphabet;
	} cfg_t;

	// symbol byte for one digit index
	function automatic logic [SYM_W-1:0] sym_at(
		input logic [NUM_SYMS*SYM_W-1:0] alpha,
		input logic [SYM_IDX_W-1:0]      d
	);
		return alpha[d*SYM_W +: SYM_W];
	endfunction

endpackage

[design/sred_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_in_if
// Input channel: one signed number per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sred_in_if #(
	parameter int VALUE_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

[design/sred_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_out_if
// Output channel: one character per beat with a last flag.
// ----------------------------------------------------------------------------
interface sred_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last;

	modport source (output valid, output out_char, output last, input ready);
	modport sink   (input valid, input out_char, input last, output ready);
endinterface

[design/signed_radix_digit_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter
// Prints a signed integer as text in a configured radix and alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   num  : one signed VALUE_BITS-bit number per beat (valid/ready).
//   chr  : one character per beat, '-' first for negatives, then the digits
//          most significant first; last marks the final character.
//   APB  : base_size at 0x00, alphabet_low at 0x08, alphabet_high at 0x10.
//          Write only while the block is idle.
// Flow: num.ready is high only when the sequencer is idle. An item goes
//   through the alphabet check (one symbol per cycle), then through the
//   shared bit-serial divider once per digit, then per emitted character
//   a stack RAM read and an output load, which waits while chr is stalled.
// An invalid alphabet ends the item after the check with no characters.
// Reset clears the registers (base_size 0, so items give no output until
//   configured) and returns the sequencer to idle.
// A stalled chr holds its beat; the sequencer waits on the output register
//   and the final character may still be pending when the next number enters.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter #(
	parameter int MAX_RADIX  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sred_in_if.sink                     num,
	sred_out_if.source                  chr,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sred_pkg::ADDR_W-1:0] paddr,
	input  logic [sred_pkg::REG_W-1:0]  pwdata,
	output logic [sred_pkg::REG_W-1:0]  prdata,
	output logic                        pready
);
	import sred_pkg::*;

	localparam int DIGIT_W = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;
	localparam int RADIX_W = DIGIT_W + 1;
	localparam int SP_W    = $clog2(VALUE_BITS + 1);
	localparam int RA_W    = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_POP,
		ST_LOAD
	} state_t;

	state_t                state_q;
	cfg_t                  cfg;
	logic [SYM_IDX_W-1:0]  i_q;
	logic [SP_W-1:0]       sp_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic                  div_start_q;
	logic                  out_valid_q;
	logic [SYM_W-1:0]      out_char_q;
	logic                  out_last_q;

	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [DIGIT_W-1:0]    div_rem;
	logic [DIGIT_W-1:0]    ram_rdata;
	logic [SYM_W-1:0]      sym_i;
	logic                  sym_bad;
	logic                  n_ok;
	logic                  check_last;
	logic                  out_free;
	logic                  out_load;
	logic                  in_neg;

	// configuration registers
	sred_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// shared divider
	sred_div #(
		.DIVIDEND_W (VALUE_BITS),
		.DIVISOR_W  (RADIX_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (mag_q),
		.divisor   (cfg.base_size[RADIX_W-1:0]),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// digit stack
	sred_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (VALUE_BITS)
	) u_stack (
		.clk   (clk),
		.we    (state_q == ST_DIV && div_done),
		.waddr (sp_q[RA_W-1:0]),
		.wdata (div_rem),
		.re    (state_q == ST_POP),
		.raddr (RA_W'(sp_q - 1'b1)),
		.rdata (ram_rdata)
	);

	// alphabet check for symbol i against the reserved characters and every later symbol in use
	always_comb begin
		sym_i   = sym_at(cfg.alphabet, i_q);
		sym_bad = (sym_i == SYM_NUL) || (sym_i == SYM_PLUS) || (sym_i == SYM_MINUS);
		for (int j = 0; j < NUM_SYMS; j++) begin
			if (SYM_IDX_W'(j) > i_q && BASE_W'(j) < cfg.base_size &&
			    sym_at(cfg.alphabet, SYM_IDX_W'(j)) == sym_i) begin
				sym_bad = 1'b1;
			end
		end
	end

	assign n_ok       = (cfg.base_size >= BASE_W'(2)) &&
	                    (cfg.base_size <= BASE_W'(MAX_RADIX));
	assign check_last = (i_q == SYM_IDX_W'(cfg.base_size - 1'b1));
	assign out_free   = !out_valid_q || chr.ready;
	assign out_load   = ((state_q == ST_SIGN) || (state_q == ST_LOAD)) && out_free;
	assign in_neg     = num.value[VALUE_BITS-1];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			sp_q        <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (chr.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						neg_q   <= in_neg;
						mag_q   <= in_neg ? (~num.value + 1'b1) : num.value;
						i_q     <= '0;
						sp_q    <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!n_ok || sym_bad) begin
						state_q <= ST_IDLE;
					end else if (check_last) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						sp_q  <= sp_q + 1'b1;
						mag_q <= div_quo;
						if (div_quo != '0) begin
							div_start_q <= 1'b1;
						end else if (neg_q) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_char_q <= SYM_MINUS;
						out_last_q <= 1'b0;
						state_q    <= ST_POP;
					end
				end
				ST_POP: begin
					sp_q    <= sp_q - 1'b1;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_char_q <= sym_at(cfg.alphabet, SYM_IDX_W'(ram_rdata));
						out_last_q <= (sp_q == '0);
						state_q    <= (sp_q == '0) ? ST_IDLE : ST_POP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// channel drive
	assign num.ready    = (state_q == ST_IDLE);
	assign chr.valid    = out_valid_q;
	assign chr.out_char = out_char_q;
	assign chr.last     = out_last_q;
endmodule

[design/sred_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sred_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/sred_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module sred_div #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-2:0]  remainder
);
	localparam int REM_W = DIVISOR_W - 1;
	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [DIVISOR_W-1:0]  trial;
	logic                  ge;

	// one shift-subtract step
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge    = (trial >= divisor);

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? REM_W'(trial - divisor) : REM_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

[design/sred_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sred_regs
// APB register file: radix and the two alphabet words.
// ----------------------------------------------------------------------------
module sred_regs (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [sred_pkg::ADDR_W-1:0] paddr,
	input  logic [sred_pkg::REG_W-1:0]  pwdata,
	output logic [sred_pkg::REG_W-1:0]  prdata,
	output logic                   pready,
	output sred_pkg::cfg_t         cfg
);
	import sred_pkg::*;

	typedef enum logic [1:0] {
		REG_BASE_SIZE = 2'd0,
		REG_ALPHA_LO  = 2'd1,
		REG_ALPHA_HI  = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	logic [BASE_W-1:0] base_size_q;
	logic [REG_W-1:0]  alpha_lo_q;
	logic [REG_W-1:0]  alpha_hi_q;
	reg_idx_t          idx;
	logic              wr_en;

	assign idx    = reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q <= '0;
			alpha_lo_q  <= '0;
			alpha_hi_q  <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE_SIZE: base_size_q <= pwdata[BASE_W-1:0];
				REG_ALPHA_LO:  alpha_lo_q  <= pwdata;
				REG_ALPHA_HI:  alpha_hi_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_BASE_SIZE: prdata = REG_W'(base_size_q);
			REG_ALPHA_LO:  prdata = alpha_lo_q;
			REG_ALPHA_HI:  prdata = alpha_hi_q;
			default:       prdata = '0;
		endcase
	end

	assign cfg.base_size = base_size_q;
	assign cfg.alphabet  = {alpha_hi_q, alpha_lo_q};
endmodule

[tb/tb_signed_radix_digit_emitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_radix_digit_emitter
// Self-checking bench for the radix digit emitter. Numbers go in over the
// num channel while the APB port sets radix and alphabet between phases. A
// scoreboard spells every accepted number in the current radix and checks
// each character beat on chr, including the last flag. Directed phases cover
// the value extremes and every kind of invalid alphabet. Random phases follow, with
// bursty input, a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_signed_radix_digit_emitter;
	import sred_pkg::*;

	localparam int     VALUE_BITS    = 32;
	localparam int     RANDOM_ITEMS  = 250;
	localparam int     SETTLE_CYCLES = 1300;
	localparam int     DRAIN_BOUND   = 40000;
	localparam int     HOLD_CYCLES   = 2500;
	localparam longint CYCLE_LIMIT   = 2000000;

	typedef enum int {
		REG_BASE_SIZE     = 0,
		REG_ALPHABET_LOW  = 1,
		REG_ALPHABET_HIGH = 2,
		REG_UNMAPPED      = 3
	} reg_idx_t;

	typedef enum int {CFG_GOOD, CFG_SHORT, CFG_WIDE, CFG_BAD_SYMBOL, CFG_REPEAT} cfg_kind_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		logic [SYM_W-1:0] ch;
		logic             last;
	} char_beat_t;

	// "01234567", "89" with unused junk, "89abcdef", binary with unused junk
	localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
	localparam logic [63:0] DEC_HI = 64'h2D2B_0000_0000_3938;
	localparam logic [63:0] HEX_HI = 64'h6665_6463_6261_3938;
	localparam logic [63:0] BIN_LO = 64'h2D2B_0000_3130_3130;

	// spells accepted numbers and checks the character beats against them
	class radix_text_sb;
		localparam int MAX_REPORTS = 40;

		logic [BASE_W-1:0] radix;
		logic [63:0]       alpha_lo;
		logic [63:0]       alpha_hi;
		char_beat_t        pending_chars[$];
		int                errors;
		int                reports;
		int                numbers_seen;
		int                silent_numbers;
		int                chars_checked;

		function new();
			radix          = '0;
			alpha_lo       = '0;
			alpha_hi       = '0;
			errors         = 0;
			reports        = 0;
			numbers_seen   = 0;
			silent_numbers = 0;
			chars_checked  = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [63:0] data);
			case (idx)
			REG_BASE_SIZE:     radix = data[BASE_W-1:0];
			REG_ALPHABET_LOW:  alpha_lo = data;
			REG_ALPHABET_HIGH: alpha_hi = data;
			default: ;
			endcase
		endfunction

		function logic [SYM_W-1:0] symbol(int unsigned d);
			logic [127:0] syms;
			syms = {alpha_hi, alpha_lo};
			return syms[d*SYM_W +: SYM_W];
		endfunction

		// radix in range, no reserved or repeated symbol among those in use
		function bit alphabet_ok();
			logic [SYM_W-1:0] s;
			int               n;
			n = radix;
			if (n < 2 || n > NUM_SYMS)
				return 1'b0;
			for (int i = 0; i < n; i++) begin
				s = symbol(i);
				if (s == SYM_NUL || s == SYM_PLUS || s == SYM_MINUS)
					return 1'b0;
				for (int j = i + 1; j < n; j++)
					if (symbol(j) == s)
						return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_number(logic [VALUE_BITS-1:0] raw);
			logic [VALUE_BITS-1:0] mag;
			int unsigned           digs[$];
			int unsigned           r;
			numbers_seen++;
			if (!alphabet_ok()) begin
				silent_numbers++;
				return;
			end
			r = radix;
			// most negative value wraps to 2^31, which is its true magnitude
			mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
			do begin
				digs.push_back(mag % r);
				mag = mag / r;
			end while (mag != 0);
			if (raw[VALUE_BITS-1])
				pending_chars.push_back('{ch: SYM_MINUS, last: 1'b0});
			for (int i = digs.size() - 1; i >= 0; i--)
				pending_chars.push_back('{ch: symbol(digs[i]), last: (i == 0)});
		endfunction

		function void check_char(logic [SYM_W-1:0] ch, logic last);
			char_beat_t want;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("[%0t] extra beat: expected none, actual char 0x%02h last %0b",
						$time, ch, last);
				return;
			end
			want = pending_chars.pop_front();
			if (ch !== want.ch) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("[%0t] out_char mismatch: expected 0x%02h, actual 0x%02h",
						$time, want.ch, ch);
			end
			if (last !== want.last) begin
				errors++;
				if (reports++ < MAX_REPORTS)
					$display("[%0t] last mismatch: expected %0b, actual %0b",
						$time, want.last, last);
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	sred_in_if #(.VALUE_BITS(VALUE_BITS)) num_if ();
	sred_out_if                           chr_if ();

	radix_text_sb sb = new();

	longint   cycle_no   = 0;
	int       reg_writes = 0;
	int       burst_left = 0;
	int       hold_left  = 0;
	int       holds_done = 0;
	int       rx_left    = 0;
	bit       hold_req   = 1'b0;
	rx_mode_t rx_mode    = RX_OPEN;

	signed_radix_digit_emitter #(
		.MAX_RADIX (16),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.chr    (chr_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no > CYCLE_LIMIT) begin
			$display("[%0t] run limit reached, %0d characters still expected",
				$time, sb.pending_chars.size());
			$display("signed_radix_digit_emitter regression: fail");
			$finish;
		end
	end

	// character beat monitor
	always @(posedge clk) begin
		if (arst_n && chr_if.valid && chr_if.ready)
			sb.check_char(chr_if.out_char, chr_if.last);
	end

	// output stall pattern, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			chr_if.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			holds_done++;
			hold_left = HOLD_CYCLES;
			chr_if.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 300);
			end
			rx_left--;
			case (rx_mode)
			RX_OPEN:   chr_if.ready <= 1'b1;
			RX_COIN:   chr_if.ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: chr_if.ready <= ($urandom_range(0, 3) == 0);
			default:   chr_if.ready <= ((cycle_no % 7) < 4);
			endcase
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [63:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 8);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_cfg(logic [63:0] base_word, logic [63:0] lo, logic [63:0] hi);
		apb_write(REG_BASE_SIZE, base_word);
		apb_write(REG_ALPHABET_LOW, lo);
		apb_write(REG_ALPHABET_HIGH, hi);
	endtask

	// one number beat, preceded by a random gap at the start of each burst
	task automatic offer(logic [VALUE_BITS-1:0] v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				num_if.valid <= 1'b0;
				num_if.value <= $urandom;
			end
		end
		burst_left--;
		@(negedge clk);
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do @(posedge clk); while (!num_if.ready);
		sb.note_number(v);
	endtask

	// stop offering, let every expected beat arrive, then let the block go idle
	task automatic settle();
		int k;
		@(negedge clk);
		num_if.valid <= 1'b0;
		for (k = 0; k < DRAIN_BOUND && sb.pending_chars.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic probe_cfg(logic [63:0] base_word, logic [63:0] lo, logic [63:0] hi,
		logic [VALUE_BITS-1:0] v);
		write_cfg(base_word, lo, hi);
		offer(v);
		settle();
	endtask

	// distinct legal symbols, then maybe one defect of a random kind
	task automatic random_cfg(bit force_good);
		bit           used [256];
		logic [127:0] syms;
		logic [63:0]  base_word;
		cfg_kind_t    kind;
		int           n;
		int           i;
		int           j;
		int           b;
		kind = (force_good || $urandom_range(0, 4) != 0) ? CFG_GOOD
			: cfg_kind_t'($urandom_range(1, 4));
		n = ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(3, NUM_SYMS);
		syms = {$urandom, $urandom, $urandom, $urandom};
		for (i = 0; i < n; i++) begin
			do b = $urandom_range(1, 255); while (b == SYM_PLUS || b == SYM_MINUS || used[b]);
			used[b] = 1'b1;
			syms[i*SYM_W +: SYM_W] = b[SYM_W-1:0];
		end
		case (kind)
		CFG_SHORT: n = $urandom_range(0, 1);
		CFG_WIDE:  n = $urandom_range(NUM_SYMS + 1, 31);
		CFG_BAD_SYMBOL: begin
			i = $urandom_range(0, n - 1);
			case ($urandom_range(0, 2))
			0:       syms[i*SYM_W +: SYM_W] = SYM_NUL;
			1:       syms[i*SYM_W +: SYM_W] = SYM_PLUS;
			default: syms[i*SYM_W +: SYM_W] = SYM_MINUS;
			endcase
		end
		CFG_REPEAT: begin
			i = $urandom_range(0, n - 1);
			j = (i + $urandom_range(1, n - 1)) % n;
			syms[j*SYM_W +: SYM_W] = syms[i*SYM_W +: SYM_W];
		end
		default: ;
		endcase
		base_word = {$urandom, $urandom};
		base_word[BASE_W-1:0] = n[BASE_W-1:0];
		if ($urandom_range(0, 3) == 0)
			apb_write(REG_UNMAPPED, {$urandom, $urandom});
		write_cfg(base_word, syms[63:0], syms[127:64]);
	endtask

	// mix of extremes, small values, full-range and random-length values
	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] v;
		int                    w;
		case ($urandom_range(0, 9))
		0: begin
			case ($urandom_range(0, 4))
			0:       v = '0;
			1:       v = 32'h7FFF_FFFF;
			2:       v = 32'h8000_0000;
			3:       v = 32'h8000_0001;
			default: v = '1;
			endcase
		end
		1, 2:    v = $urandom_range(0, 600) - 300;
		3, 4, 5: v = $urandom;
		default: begin
			w = $urandom_range(1, 31);
			v = $urandom >> (32 - w);
			if ($urandom_range(0, 1))
				v = -v;
		end
		endcase
		return v;
	endfunction

	initial begin
		int phase;
		int random_done;
		phase        = 0;
		random_done  = 0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		num_if.valid = 1'b0;
		num_if.value = '0;
		chr_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// registers at reset give radix 0, so nothing comes out
		offer(32'd5);
		offer(32'h8000_0000);
		settle();

		// decimal, junk above the radix field, plus a write that decodes to nothing
		apb_write(REG_BASE_SIZE, 64'hFFFF_FFFF_FFFF_FFEA);
		apb_write(REG_ALPHABET_LOW, DEC_LO);
		apb_write(REG_ALPHABET_HIGH, DEC_HI);
		apb_write(REG_UNMAPPED, '1);
		offer(32'd0);
		offer(32'd7);
		offer(-1);
		offer(32'h7FFF_FFFF);
		offer(32'h8000_0000);
		offer(-305);
		settle();

		// hex, every symbol in use
		write_cfg(64'd16, DEC_LO, HEX_HI);
		offer(32'h8000_0000);
		offer(32'h7FFF_FFFF);
		offer(32'h7EDC_BA98);
		offer(32'h0123_4567);
		settle();

		// binary, longest digit strings
		write_cfg(64'd2, BIN_LO, HEX_HI);
		offer(32'h8000_0000);
		offer(32'd5);
		offer(-1);
		settle();

		// invalid alphabets: radix too small, too large, reserved and repeated symbols
		probe_cfg(64'd1, DEC_LO, DEC_HI, 32'd42);
		probe_cfg(64'd17, DEC_LO, HEX_HI, 32'd42);
		probe_cfg(64'd31, DEC_LO, HEX_HI, -42);
		probe_cfg(64'd16, DEC_LO, {HEX_HI[63:32], SYM_NUL, HEX_HI[23:0]}, 32'd99);
		probe_cfg(64'd10, {DEC_LO[63:40], SYM_PLUS, DEC_LO[31:0]}, DEC_HI, 32'd99);
		probe_cfg(64'd16, DEC_LO, {SYM_MINUS, HEX_HI[55:0]}, -99);
		probe_cfg(64'd10, DEC_LO, {DEC_HI[63:16], 8'h39, 8'h30}, 32'd99);

		// random phases; the second one starts under a long output hold-off
		while (random_done < RANDOM_ITEMS) begin
			random_cfg(phase == 1);
			if (phase == 1) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			repeat ($urandom_range(3, 14)) begin
				offer(pick_value());
				random_done++;
			end
			settle();
			phase++;
		end

		if (sb.pending_chars.size() != 0) begin
			$display("[%0t] %0d expected character(s) never arrived",
				$time, sb.pending_chars.size());
			sb.errors += sb.pending_chars.size();
		end
		$display("covered %0d numbers (%0d under invalid alphabets), %0d characters checked",
			sb.numbers_seen, sb.silent_numbers, sb.chars_checked);
		$display("%0d register writes over %0d random phases, %0d long output hold-off(s)",
			reg_writes, phase, holds_done);
		if (sb.errors == 0)
			$display("signed_radix_digit_emitter regression: pass");
		else
			$display("signed_radix_digit_emitter regression: fail");
		$finish;
	end

endmodule

[signed_radix_digit_emitter.f]
design/sred_pkg.sv
design/sred_in_if.sv
design/sred_out_if.sv
design/sred_ram.sv
design/sred_div.sv
design/sred_regs.sv
design/signed_radix_digit_emitter.sv
tb/tb_signed_radix_digit_emitter.sv
